// ===== hdl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Checksummed packet deframer package
// Shared types and constants: transaction payloads, register map, state codes.
// ----------------------------------------------------------------------------
package cpd_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] device_type;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       captured;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] match_type;
    logic [7:0] match_command;
  } cfg_regs_t;

  // Packet header details handed from the parser to the emitter.
  typedef struct packed {
    logic [7:0] device_type;
    logic [7:0] command;
    logic       captured;
  } pkt_info_t;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_MATCH_TYPE    = 2'd2,
    REG_MATCH_COMMAND = 2'd3
  } reg_idx_t;

  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0] MATCH_TYPE_RST    = 8'h09;
  localparam logic [7:0] MATCH_COMMAND_RST = 8'h50;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_CMD   = 3'd3,
    PH_LEN   = 3'd4,
    PH_DATA  = 3'd5,
    PH_SUM   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE  = 2'd0,
    EM_FETCH = 2'd1,
    EM_SHOW  = 2'd2
  } emit_state_t;

endpackage

// ===== hdl/cpd_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the header and match values.
// ----------------------------------------------------------------------------
module cpd_regs
  import cpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_regs_t             regs
);

  cfg_regs_t  regs_r;
  cfg_regs_t  regs_nxt;
  reg_idx_t   idx;
  logic       wr_en;
  logic [7:0] rd_val;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign regs   = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    rd_val   = 8'h00;
    case (idx)
      REG_HEADER_FIRST: begin
        rd_val = regs_r.header_first;
        if (wr_en) regs_nxt.header_first = pwdata[7:0];
      end
      REG_HEADER_SECOND: begin
        rd_val = regs_r.header_second;
        if (wr_en) regs_nxt.header_second = pwdata[7:0];
      end
      REG_MATCH_TYPE: begin
        rd_val = regs_r.match_type;
        if (wr_en) regs_nxt.match_type = pwdata[7:0];
      end
      REG_MATCH_COMMAND: begin
        rd_val = regs_r.match_command;
        if (wr_en) regs_nxt.match_command = pwdata[7:0];
      end
      default: begin
        rd_val = 8'h00;
      end
    endcase
  end

  assign prdata = {24'h000000, rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.header_first  <= HEADER_FIRST_RST;
      regs_r.header_second <= HEADER_SECOND_RST;
      regs_r.match_type    <= MATCH_TYPE_RST;
      regs_r.match_command <= MATCH_COMMAND_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== hdl/cpd_store.sv =====
// ----------------------------------------------------------------------------
// Payload store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module cpd_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/cpd_parse.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Tracks sync, header and payload bytes, checks the sum and holds the armed flag.
// ----------------------------------------------------------------------------
module cpd_parse
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW          = 5,
  parameter int unsigned LEN_W       = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  in_item_t         item,
  input  cfg_regs_t        regs,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data,
  output logic             start,
  output pkt_info_t        info,
  output logic [LEN_W-1:0] len
);

  localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

  phase_t           phase_r,  phase_nxt;
  logic [7:0]       sum_r,    sum_nxt;
  logic [7:0]       type_r,   type_nxt;
  logic [7:0]       cmd_r,    cmd_nxt;
  logic [LEN_W-1:0] len_r,    len_nxt;
  logic [LEN_W-1:0] fill_r,   fill_nxt;
  logic             armed_r,  armed_nxt;
  logic [7:0]       b;
  logic [7:0]       sum_add;
  logic [LEN_W-1:0] fill_inc;
  logic             cap;

  assign b        = item.rx_byte;
  assign sum_add  = sum_r + b;
  assign fill_inc = fill_r + LEN_W'(1);
  assign cap      = armed_r && (type_r == regs.match_type) && (cmd_r == regs.match_command);

  assign wr_addr = fill_r[AW-1:0];
  assign wr_data = b;
  assign len     = len_r;
  assign info    = '{device_type: type_r, command: cmd_r, captured: cap};

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    armed_nxt = armed_r;
    wr_en     = 1'b0;
    start     = 1'b0;
    if (accept && item.action) begin
      armed_nxt = 1'b1;
    end else if (accept) begin
      case (phase_r)
        PH_HEAD2: begin
          if (b == regs.header_second) phase_nxt = PH_TYPE;
          else if (b != regs.header_first) phase_nxt = PH_HEAD1;
        end
        PH_TYPE: begin
          sum_nxt   = b;
          type_nxt  = b;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          sum_nxt   = sum_add;
          cmd_nxt   = b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          sum_nxt  = sum_add;
          len_nxt  = b[LEN_W-1:0];
          fill_nxt = '0;
          if (b > MAX_B) phase_nxt = PH_HEAD1;
          else if (b == 8'h00) phase_nxt = PH_SUM;
          else phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          sum_nxt  = sum_add;
          wr_en    = 1'b1;
          fill_nxt = fill_inc;
          if (fill_inc >= len_r) phase_nxt = PH_SUM;
        end
        PH_SUM: begin
          if (~sum_r == b) begin
            start = 1'b1;
            if (cap) armed_nxt = 1'b0;
          end
          phase_nxt = PH_HEAD1;
        end
        default: begin
          if (b == regs.header_first) phase_nxt = PH_HEAD2;
          else phase_nxt = PH_HEAD1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD1;
      sum_r   <= '0;
      type_r  <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      fill_r  <= '0;
      armed_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

// ===== hdl/cpd_emit.sv =====
// ----------------------------------------------------------------------------
// Result emitter
// Reads a checked packet from the store, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module cpd_emit
  import cpd_pkg::*;
#(
  parameter int unsigned AW    = 5,
  parameter int unsigned LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pkt_info_t        info,
  input  logic [LEN_W-1:0] len,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  logic [7:0]       rd_data,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  emit_state_t      state_r, state_nxt;
  pkt_info_t        info_r,  info_nxt;
  logic [LEN_W-1:0] len_r,   len_nxt;
  logic [AW-1:0]    idx_r,   idx_nxt;
  logic             zero_r,  zero_nxt;
  logic [LEN_W-1:0] idx_inc;
  logic             is_last;
  logic [7:0]       len8;
  logic [7:0]       idx8;

  assign idx_inc = LEN_W'(idx_r) + LEN_W'(1);
  assign is_last = zero_r || (idx_inc == len_r);
  assign len8    = 8'(len_r);
  assign idx8    = 8'(idx_r);
  assign busy    = (state_r != EM_IDLE);

  always_comb begin
    state_nxt = state_r;
    info_nxt  = info_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    zero_nxt  = zero_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    out_valid = 1'b0;
    case (state_r)
      EM_IDLE: begin
        if (start) begin
          info_nxt  = info;
          len_nxt   = len;
          idx_nxt   = '0;
          zero_nxt  = (len == '0);
          state_nxt = (len == '0) ? EM_SHOW : EM_FETCH;
        end
      end
      EM_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = EM_SHOW;
      end
      EM_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (is_last) begin
            state_nxt = EM_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
            idx_nxt = idx_inc[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data.device_type    = info_r.device_type;
    out_data.command        = info_r.command;
    out_data.payload_length = len8[5:0];
    out_data.byte_index     = idx8[4:0];
    out_data.payload_byte   = zero_r ? 8'h00 : rd_data;
    out_data.captured       = info_r.captured;
    out_data.last           = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    info_r <= info_nxt;
    len_r  <= len_nxt;
    idx_r  <= idx_nxt;
    zero_r <= zero_nxt;
  end

endmodule

// ===== hdl/checksummed_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Checksummed packet deframer
// Finds framed packets in a received byte stream and emits their payloads.
// ----------------------------------------------------------------------------
// Each input transaction carries either a received byte or a re-arm request.
// Bytes are framed as two sync bytes, type, command, length, payload and an
// inverted-sum checksum. A packet that passes the check is delivered on the
// output channel as one transaction per payload byte, or one transaction when
// the length is zero; failed packets are discarded with no output.
// Input bytes are taken one per cycle while no packet is being delivered.
// After the checksum byte the emitter fetches the first payload byte and
// shows it (zero-length packets skip the fetch), then one result per cycle,
// limited by the store's single read port. The input channel is stalled from
// the cycle after the checksum byte until the last result has been taken.
// A stall on the output channel holds the current result unchanged.
// Reset returns the parser to hunting for the first sync byte, sets the
// capture flag armed and loads the register defaults; no clearing pass runs.
// The configuration port is an APB-style slave with four byte registers.
// ----------------------------------------------------------------------------
module checksummed_packet_deframer_top
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  cfg_regs_t        regs;
  logic             accept;
  logic             busy;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             start;
  pkt_info_t        info;
  logic [LEN_W-1:0] len;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  cpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  cpd_store #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cpd_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .LEN_W       (LEN_W)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_data),
    .regs    (regs),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .start   (start),
    .info    (info),
    .len     (len)
  );

  cpd_emit #(
    .AW    (AW),
    .LEN_W (LEN_W)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .info      (info),
    .len       (len),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/deframe_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer checking package
// Predicts the result transactions of the checksummed packet deframer from
// the input transactions it accepts, and checks each delivered result in order.
// ----------------------------------------------------------------------------
package deframe_check_pkg;
  import cpd_pkg::*;

  localparam int unsigned PAYLOAD_CAP = 32;

  class deframe_tracker;
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    logic [7:0] want_type;
    logic [7:0] want_cmd;
    phase_t     parse_phase;
    logic [7:0] sum_acc;
    logic [7:0] pkt_type;
    logic [7:0] pkt_cmd;
    logic [7:0] pkt_len;
    logic [5:0] fill_pos;
    logic [7:0] payload_mem [PAYLOAD_CAP];
    bit         capture_armed;
    out_item_t  pending_payloads[$];
    int         mismatches;

    function new();
      hdr_first     = HEADER_FIRST_RST;
      hdr_second    = HEADER_SECOND_RST;
      want_type     = MATCH_TYPE_RST;
      want_cmd      = MATCH_COMMAND_RST;
      parse_phase   = PH_HEAD1;
      sum_acc       = '0;
      pkt_type      = '0;
      pkt_cmd       = '0;
      pkt_len       = '0;
      fill_pos      = '0;
      capture_armed = 1'b1;
      mismatches    = 0;
      foreach (payload_mem[i]) payload_mem[i] = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_HEADER_FIRST:  hdr_first = val;
        REG_HEADER_SECOND: hdr_second = val;
        REG_MATCH_TYPE:    want_type = val;
        REG_MATCH_COMMAND: want_cmd = val;
        default: ;
      endcase
    endfunction

    function void take_rx_item(in_item_t it);
      out_item_t  r;
      bit         cap;
      logic [7:0] b;
      b = it.rx_byte;
      if (it.action) begin
        capture_armed = 1'b1;
        return;
      end
      case (parse_phase)
        PH_HEAD2: begin
          if (b == hdr_second) parse_phase = PH_TYPE;
          else if (b != hdr_first) parse_phase = PH_HEAD1;
        end
        PH_TYPE: begin
          sum_acc     = b;
          pkt_type    = b;
          parse_phase = PH_CMD;
        end
        PH_CMD: begin
          sum_acc     = sum_acc + b;
          pkt_cmd     = b;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          sum_acc  = sum_acc + b;
          pkt_len  = b;
          fill_pos = '0;
          if (b > PAYLOAD_CAP) parse_phase = PH_HEAD1;
          else if (b == 8'd0) parse_phase = PH_SUM;
          else parse_phase = PH_DATA;
        end
        PH_DATA: begin
          sum_acc                   = sum_acc + b;
          payload_mem[fill_pos[4:0]] = b;
          fill_pos                  = fill_pos + 6'd1;
          if (fill_pos >= pkt_len) parse_phase = PH_SUM;
        end
        PH_SUM: begin
          if (8'(~sum_acc) == b) begin
            cap = capture_armed && pkt_type == want_type && pkt_cmd == want_cmd;
            if (cap) capture_armed = 1'b0;
            r.device_type    = pkt_type;
            r.command        = pkt_cmd;
            r.payload_length = pkt_len[5:0];
            r.captured       = cap;
            if (pkt_len == 8'd0) begin
              r.byte_index   = '0;
              r.payload_byte = '0;
              r.last         = 1'b1;
              pending_payloads.push_back(r);
            end else begin
              for (int i = 0; i < pkt_len; i++) begin
                r.byte_index   = 5'(i);
                r.payload_byte = payload_mem[5'(i)];
                r.last         = (i + 1 == pkt_len);
                pending_payloads.push_back(r);
              end
            end
          end
          parse_phase = PH_HEAD1;
        end
        default: begin
          if (b == hdr_first) parse_phase = PH_HEAD2;
          else parse_phase = PH_HEAD1;
        end
      endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (pending_payloads.size() == 0) begin
        $display("%0t: result with none expected, got %0h", $time, got);
        mismatches++;
        return;
      end
      want = pending_payloads.pop_front();
      check_field("device_type", want.device_type, got.device_type);
      check_field("command", want.command, got.command);
      check_field("payload_length", 8'(want.payload_length), 8'(got.payload_length));
      check_field("byte_index", 8'(want.byte_index), 8'(got.byte_index));
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("captured", 8'(want.captured), 8'(got.captured));
      check_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

endpackage

// ===== dv/tb_checksummed_packet_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed packet deframer testbench
// Drives framed byte streams, re-arm requests and register writes into the
// deframer under varying idle and stall patterns, and checks every delivered
// payload transaction against an independent prediction.
// ----------------------------------------------------------------------------
module tb_checksummed_packet_deframer_top;
  import cpd_pkg::*;
  import deframe_check_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  deframe_tracker tracker;
  in_item_t       frame_q[$];
  logic [7:0]     cfg_val [4];
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             sent_count = 0;

  checksummed_packet_deframer_top #(.MAX_PAYLOAD(PAYLOAD_CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(out_data);
  end

  task automatic send_item(in_item_t it);
    bit stalled;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    tracker.take_rx_item(it);
    sent_count++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_item(frame_q[i]);
    frame_q.delete();
  endtask

  function automatic void put_byte(logic [7:0] b);
    in_item_t it;
    it.action  = 1'b0;
    it.rx_byte = b;
    frame_q.push_back(it);
  endfunction

  function automatic void put_rearm(logic [7:0] junk);
    in_item_t it;
    it.action  = 1'b1;
    it.rx_byte = junk;
    frame_q.push_back(it);
  endfunction

  function automatic void build_packet(logic [7:0] hf, logic [7:0] hs, logic [7:0] typ,
                                       logic [7:0] cmd, int len, bit corrupt,
                                       int extra_heads);
    logic [7:0] sum;
    logic [7:0] b;
    sum = typ + cmd + 8'(len);
    for (int i = 0; i <= extra_heads; i++) put_byte(hf);
    put_byte(hs);
    put_byte(typ);
    put_byte(cmd);
    put_byte(8'(len));
    if (len <= PAYLOAD_CAP) begin
      for (int i = 0; i < len; i++) begin
        b   = 8'($urandom_range(255));
        sum = sum + b;
        put_byte(b);
      end
      put_byte(~sum ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'd0));
    end
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_payloads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    bit ready;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = cfg_pready;
      @(posedge clk);
    end while (!ready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_reg(idx, val);
    cfg_val[idx] = val;
  endtask

  task automatic set_config(logic [7:0] hf, logic [7:0] hs, logic [7:0] typ,
                            logic [7:0] cmd);
    write_reg(REG_HEADER_FIRST, hf);
    write_reg(REG_HEADER_SECOND, hs);
    write_reg(REG_MATCH_TYPE, typ);
    write_reg(REG_MATCH_COMMAND, cmd);
  endtask

  task automatic run_random(int quota);
    int         kind;
    int         len;
    int         pick;
    logic [7:0] typ;
    logic [7:0] cmd;
    sent_count = 0;
    while (sent_count < quota) begin
      kind = $urandom_range(99);
      typ  = $urandom_range(1) ? cfg_val[REG_MATCH_TYPE] : 8'($urandom_range(255));
      cmd  = $urandom_range(1) ? cfg_val[REG_MATCH_COMMAND] : 8'($urandom_range(255));
      pick = $urandom_range(19);
      if (pick == 0) len = PAYLOAD_CAP;
      else if (pick < 3) len = $urandom_range(0, PAYLOAD_CAP);
      else len = $urandom_range(0, 5);
      if (kind < 65) begin
        build_packet(cfg_val[REG_HEADER_FIRST], cfg_val[REG_HEADER_SECOND], typ, cmd, len,
                     1'b0, ($urandom_range(3) == 0) ? 1 : 0);
      end else if (kind < 77) begin
        build_packet(cfg_val[REG_HEADER_FIRST], cfg_val[REG_HEADER_SECOND], typ, cmd, len,
                     1'b1, 0);
      end else if (kind < 84) begin
        build_packet(cfg_val[REG_HEADER_FIRST], cfg_val[REG_HEADER_SECOND], typ, cmd,
                     $urandom_range(PAYLOAD_CAP + 1, 255), 1'b0, 0);
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 4)) begin
          put_byte(($urandom_range(3) == 0) ? cfg_val[REG_HEADER_FIRST]
                                            : 8'($urandom_range(255)));
        end
      end else begin
        put_rearm(8'($urandom_range(255)));
      end
      send_frame();
    end
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    idle_set  = '{0, 61, 0, 16};
    stall_set = '{0, 0, 61, 16};
    tracker = new();
    cfg_val[REG_HEADER_FIRST]  = HEADER_FIRST_RST;
    cfg_val[REG_HEADER_SECOND] = HEADER_SECOND_RST;
    cfg_val[REG_MATCH_TYPE]    = MATCH_TYPE_RST;
    cfg_val[REG_MATCH_COMMAND] = MATCH_COMMAND_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Repeated first sync byte, empty packet that captures, then a one-byte
    // packet of the same type and command once the flag is spent, a re-arm,
    // an oversized length and a corrupted checksum.
    build_packet(HEADER_FIRST_RST, HEADER_SECOND_RST, MATCH_TYPE_RST, MATCH_COMMAND_RST,
                 0, 1'b0, 1);
    build_packet(HEADER_FIRST_RST, HEADER_SECOND_RST, MATCH_TYPE_RST, MATCH_COMMAND_RST,
                 1, 1'b0, 0);
    put_rearm(8'hFF);
    build_packet(HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h00, 8'h00, PAYLOAD_CAP + 1, 1'b0, 0);
    build_packet(HEADER_FIRST_RST, HEADER_SECOND_RST, 8'hFF, 8'hFF, 0, 1'b1, 0);
    send_frame();
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[2'(p)];
      stall_pct = stall_set[2'(p)];
      case (p)
        0: set_config(HEADER_FIRST_RST, HEADER_SECOND_RST, MATCH_TYPE_RST,
                      MATCH_COMMAND_RST);
        1: set_config(8'h00, 8'h00, 8'h00, 8'h00);
        2: set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      run_random(18);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_payloads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cpd_pkg.sv
hdl/cpd_regs.sv
hdl/cpd_store.sv
hdl/cpd_parse.sv
hdl/cpd_emit.sv
hdl/checksummed_packet_deframer_top.sv
dv/deframe_check_pkg.sv
dv/tb_checksummed_packet_deframer_top.sv
